### hdl/uvs_pkg.sv
// Shared types, constants and functions of the UV sphere mesh generator.
`default_nettype none
package uvs_pkg;

	localparam int DIV_BITS = 41;
	localparam int CNT_W = 6;
	localparam int SEL_W = 3;
	localparam int IDX_W = 5;

	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic signed [31:0] ONE30 = 32'sd1073741824;
	localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

	localparam logic [1:0] CFG_RADIUS = 2'd0;
	localparam logic [1:0] CFG_SLICES = 2'd1;
	localparam logic [1:0] CFG_STACKS = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_INIT,
		ST_DIV_RUN,
		ST_DIV_SAVE,
		ST_COR_INIT,
		ST_COR_RUN,
		ST_COR_SAVE,
		ST_MUL,
		ST_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_SAVE,
		OP_COR_INIT,
		OP_COR_STEP,
		OP_COR_SAVE,
		OP_MUL,
		OP_WRITE
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [SEL_W-1:0] sel;
		logic [IDX_W-1:0] idx;
	} dp_cmd_t;

	function automatic logic signed [31:0] atan_turn(input logic [IDX_W-1:0] i);
		logic signed [31:0] v;
		unique case (i)
			5'd0:  v = 32'sd536870912;
			5'd1:  v = 32'sd316933406;
			5'd2:  v = 32'sd167458907;
			5'd3:  v = 32'sd85004756;
			5'd4:  v = 32'sd42667331;
			5'd5:  v = 32'sd21354465;
			5'd6:  v = 32'sd10679838;
			5'd7:  v = 32'sd5340245;
			5'd8:  v = 32'sd2670163;
			5'd9:  v = 32'sd1335087;
			5'd10: v = 32'sd667544;
			5'd11: v = 32'sd333772;
			5'd12: v = 32'sd166886;
			5'd13: v = 32'sd83443;
			5'd14: v = 32'sd41722;
			5'd15: v = 32'sd20861;
			5'd16: v = 32'sd10430;
			5'd17: v = 32'sd5215;
			5'd18: v = 32'sd2608;
			5'd19: v = 32'sd1304;
			5'd20: v = 32'sd652;
			5'd21: v = 32'sd326;
			5'd22: v = 32'sd163;
			5'd23: v = 32'sd81;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### hdl/uv_sphere_mesh_generator.sv
// Top level of the UV sphere mesh generator: configuration registers, controller and datapath.
`default_nettype none
// One request in, one result out. A triangle request or a pole vertex goes from
// acceptance through ST_CHECK and ST_FIN into the output register, where ST_FIN waits
// while a held result is stalled. A ring vertex runs four divisions on one shared
// restoring divider (theta, phi, u, v), two CORDIC passes of min(CORDIC_STEPS, 24) steps
// on one shared rotator and five passes through one shared multiplier. A new
// request is taken once the previous one has finished, while its result may still wait
// in the output register. Configuration registers are written through a channel that is
// always ready.
module uv_sphere_mesh_generator
	import uvs_pkg::*;
#(
	parameter int MAX_SLICES = 256,
	parameter int MAX_STACKS = 256,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        req_type,
	input  wire logic [8:0]  row,
	input  wire logic [8:0]  col,
	input  wire logic        half,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [16:0]      pos_x,
	output logic [16:0]      pos_y,
	output logic [16:0]      pos_z,
	output logic [15:0]      norm_x,
	output logic [15:0]      norm_y,
	output logic [15:0]      norm_z,
	output logic [16:0]      tex_u,
	output logic [16:0]      tex_v,
	output logic [16:0]      index_a,
	output logic [16:0]      index_b,
	output logic [16:0]      index_c
);

	localparam logic [31:0] MAXS = MAX_SLICES;
	localparam logic [31:0] MAXT = MAX_STACKS;

	logic [15:0] radius_q;
	logic [8:0] slices_q, stacks_q, s_eff, t_eff;
	logic fast;
	dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd256;
			slices_q <= 9'd16;
			stacks_q <= 9'd16;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RADIUS: radius_q <= cfg_data;
				CFG_SLICES: slices_q <= cfg_data[8:0];
				CFG_STACKS: stacks_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (slices_q < 9'd3) s_eff = 9'd3;
		else if ({23'd0, slices_q} > MAXS) s_eff = MAXS[8:0];
		else s_eff = slices_q;
		if (stacks_q < 9'd2) t_eff = 9'd2;
		else if ({23'd0, stacks_q} > MAXT) t_eff = MAXT[8:0];
		else t_eff = stacks_q;
	end

	uvs_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fast(fast),
		.cmd(cmd)
	);

	uvs_datapath u_dp (
		.clk(clk),
		.cmd(cmd),
		.req_type(req_type),
		.row(row),
		.col(col),
		.half(half),
		.s_eff(s_eff),
		.t_eff(t_eff),
		.rad(radius_q),
		.fast(fast),
		.kind(kind),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.norm_x(norm_x),
		.norm_y(norm_y),
		.norm_z(norm_z),
		.tex_u(tex_u),
		.tex_v(tex_v),
		.index_a(index_a),
		.index_b(index_b),
		.index_c(index_c)
	);

endmodule
`default_nettype wire

### hdl/uvs_ctrl.sv
// Controller state machine that sequences the division, CORDIC and multiply steps.
`default_nettype none
module uvs_ctrl
	import uvs_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	input  wire logic fast,
	output dp_cmd_t   cmd
);

	localparam int NSTEP = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_BITS - 1);
	localparam logic [CNT_W-1:0] COR_LAST = CNT_W'(NSTEP - 1);

	state_t state_q, state_d;
	logic [SEL_W-1:0] sel_q, sel_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q, write;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q <= sel_d;
			cnt_q <= cnt_d;
			if (write) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		sel_d = sel_q;
		cnt_d = cnt_q;
		cmd.op = OP_NOP;
		cmd.sel = sel_q;
		cmd.idx = cnt_q[IDX_W-1:0];
		in_stall = 1'b1;
		write = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				sel_d = '0;
				state_d = fast ? ST_FIN : ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.op = OP_DIV_INIT;
				cnt_d = '0;
				state_d = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				cmd.op = OP_DIV_STEP;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) state_d = ST_DIV_SAVE;
			end
			ST_DIV_SAVE: begin
				cmd.op = OP_DIV_SAVE;
				if (sel_q == SEL_W'(3)) begin
					sel_d = '0;
					state_d = ST_COR_INIT;
				end else begin
					sel_d = sel_q + 1'b1;
					state_d = ST_DIV_INIT;
				end
			end
			ST_COR_INIT: begin
				cmd.op = OP_COR_INIT;
				cnt_d = '0;
				state_d = ST_COR_RUN;
			end
			ST_COR_RUN: begin
				cmd.op = OP_COR_STEP;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == COR_LAST) state_d = ST_COR_SAVE;
			end
			ST_COR_SAVE: begin
				cmd.op = OP_COR_SAVE;
				if (sel_q == SEL_W'(1)) begin
					sel_d = '0;
					state_d = ST_MUL;
				end else begin
					sel_d = sel_q + 1'b1;
					state_d = ST_COR_INIT;
				end
			end
			ST_MUL: begin
				cmd.op = OP_MUL;
				if (sel_q == SEL_W'(4)) state_d = ST_FIN;
				else sel_d = sel_q + 1'b1;
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op = OP_WRITE;
					write = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### hdl/uvs_datapath.sv
// Datapath: request latch, shared divider, CORDIC, multiplier and result register.
`default_nettype none
module uvs_datapath
	import uvs_pkg::*;
(
	input  wire logic        clk,
	input  wire dp_cmd_t     cmd,
	input  wire logic        req_type,
	input  wire logic [8:0]  row,
	input  wire logic [8:0]  col,
	input  wire logic        half,
	input  wire logic [8:0]  s_eff,
	input  wire logic [8:0]  t_eff,
	input  wire logic [15:0] rad,
	output logic             fast,
	output logic             kind,
	output logic [16:0]      pos_x,
	output logic [16:0]      pos_y,
	output logic [16:0]      pos_z,
	output logic [15:0]      norm_x,
	output logic [15:0]      norm_y,
	output logic [15:0]      norm_z,
	output logic [16:0]      tex_u,
	output logic [16:0]      tex_v,
	output logic [16:0]      index_a,
	output logic [16:0]      index_b,
	output logic [16:0]      index_c
);

	function automatic logic signed [31:0] clamp30(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd1073741824) r = ONE30;
		else if (v < -34'sd1073741824) r = -ONE30;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic [15:0] to_norm(input logic signed [31:0] d);
		logic signed [32:0] n;
		n = ($signed({d[31], d}) + 33'sd32768) >>> 16;
		return n[15:0];
	endfunction

	logic type_q, half_q;
	logic [8:0] row_q, col_q;
	logic [DIV_BITS-1:0] n_q;
	logic [8:0] r_q;
	logic [31:0] th_q, ph_q;
	logic [16:0] tu_q, tv_q;
	logic signed [31:0] x_q, y_q, z_q;
	logic [1:0] q_q;
	logic signed [31:0] ct_q, st_q, cp_q, sp_q;
	logic signed [31:0] dx_q, dy_q, dz_q;
	logic [16:0] px_q, py_q, pz_q;

	logic [8:0] row_lim, col_lim, dvs;
	logic [DIV_BITS-1:0] num;
	logic [9:0] trial, trial_sub;
	logic [31:0] ang, ang_off;
	logic signed [31:0] dx_s, dy_s, atan_i, cos_o, sin_o;
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod, prod_rnd;
	logic signed [33:0] prod30;
	logic [9:0] rlen;
	logic [19:0] south, base_mid, base_bot, next_mid, colx;
	logic [16:0] ia, ib, ic;

	assign row_lim = req_type ? t_eff - 1'b1 : t_eff;
	assign col_lim = req_type ? s_eff - 1'b1 : s_eff;
	assign fast = type_q || (row_q == 9'd0) || (row_q == t_eff);

	assign dvs = cmd.sel[0] ? t_eff : s_eff;
	always_comb begin
		unique case (cmd.sel[1:0])
			2'd0: num = {col_q, 32'd0};
			2'd1: num = {1'b0, row_q, 31'd0};
			2'd2: num = {16'd0, col_q, 16'd0} + {32'd0, 1'b0, s_eff[8:1]};
			default: num = {16'd0, row_q, 16'd0} + {32'd0, 1'b0, t_eff[8:1]};
		endcase
	end
	assign trial = {r_q, n_q[DIV_BITS-1]};
	assign trial_sub = trial - {1'b0, dvs};

	assign ang = cmd.sel[0] ? ph_q : th_q;
	assign ang_off = ang + EIGHTH_TURN;
	assign dx_s = y_q >>> cmd.idx;
	assign dy_s = x_q >>> cmd.idx;
	assign atan_i = atan_turn(cmd.idx);

	always_comb begin
		unique case (q_q)
			2'd0: begin cos_o = x_q; sin_o = y_q; end
			2'd1: begin cos_o = -y_q; sin_o = x_q; end
			2'd2: begin cos_o = -x_q; sin_o = -y_q; end
			default: begin cos_o = y_q; sin_o = -x_q; end
		endcase
	end

	always_comb begin
		ma = $signed({16'd0, rad});
		mb = dx_q;
		unique case (cmd.sel)
			3'd0: begin ma = sp_q; mb = ct_q; end
			3'd1: begin ma = sp_q; mb = st_q; end
			3'd2: mb = dx_q;
			3'd3: mb = dy_q;
			default: mb = dz_q;
		endcase
	end
	assign prod = ma * mb;
	assign prod_rnd = (prod + 64'sd536870912) >>> 30;
	assign prod30 = prod_rnd[33:0];

	assign rlen = {1'b0, s_eff} + 10'd1;
	assign colx = {11'd0, col_q};
	assign south = 20'd1 + (20'(t_eff) - 20'd1) * 20'(rlen);
	assign base_mid = 20'd1 + (20'(row_q) - 20'd1) * 20'(rlen);
	assign next_mid = base_mid + 20'(rlen);
	assign base_bot = south - 20'(rlen);

	always_comb begin
		if (row_q == 9'd0) begin
			ia = '0;
			ib = 17'(colx + 20'd2);
			ic = 17'(colx + 20'd1);
		end else if (row_q == t_eff - 1'b1) begin
			ia = south[16:0];
			ib = 17'(base_bot + colx);
			ic = 17'(base_bot + colx + 20'd1);
		end else if (!half_q) begin
			ia = 17'(base_mid + colx);
			ib = 17'(base_mid + colx + 20'd1);
			ic = 17'(next_mid + colx);
		end else begin
			ia = 17'(next_mid + colx);
			ib = 17'(base_mid + colx + 20'd1);
			ic = 17'(next_mid + colx + 20'd1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				type_q <= req_type;
				half_q <= half;
				row_q <= (row > row_lim) ? row_lim : row;
				col_q <= (col > col_lim) ? col_lim : col;
			end
			OP_DIV_INIT: begin
				n_q <= num;
				r_q <= '0;
			end
			OP_DIV_STEP: begin
				if (trial >= {1'b0, dvs}) begin
					r_q <= trial_sub[8:0];
					n_q <= {n_q[DIV_BITS-2:0], 1'b1};
				end else begin
					r_q <= trial[8:0];
					n_q <= {n_q[DIV_BITS-2:0], 1'b0};
				end
			end
			OP_DIV_SAVE: begin
				unique case (cmd.sel[1:0])
					2'd0: th_q <= n_q[31:0];
					2'd1: ph_q <= n_q[31:0];
					2'd2: tu_q <= n_q[16:0];
					default: tv_q <= n_q[16:0];
				endcase
			end
			OP_COR_INIT: begin
				q_q <= ang_off[31:30];
				z_q <= $signed({2'b00, ang_off[29:0]}) - $signed(EIGHTH_TURN);
				x_q <= CORDIC_GAIN;
				y_q <= '0;
			end
			OP_COR_STEP: begin
				if (z_q >= 0) begin
					x_q <= x_q - dx_s;
					y_q <= y_q + dy_s;
					z_q <= z_q - atan_i;
				end else begin
					x_q <= x_q + dx_s;
					y_q <= y_q - dy_s;
					z_q <= z_q + atan_i;
				end
			end
			OP_COR_SAVE: begin
				if (cmd.sel[0]) begin
					cp_q <= cos_o;
					sp_q <= sin_o;
				end else begin
					ct_q <= cos_o;
					st_q <= sin_o;
				end
			end
			OP_MUL: begin
				unique case (cmd.sel)
					3'd0: dx_q <= clamp30(prod30);
					3'd1: begin
						dz_q <= clamp30(prod30);
						dy_q <= clamp30({{2{cp_q[31]}}, cp_q});
					end
					3'd2: px_q <= prod30[16:0];
					3'd3: py_q <= prod30[16:0];
					default: pz_q <= prod30[16:0];
				endcase
			end
			OP_WRITE: begin
				kind <= type_q;
				pos_x <= '0;
				pos_y <= '0;
				pos_z <= '0;
				norm_x <= '0;
				norm_y <= '0;
				norm_z <= '0;
				tex_u <= '0;
				tex_v <= '0;
				index_a <= '0;
				index_b <= '0;
				index_c <= '0;
				if (type_q) begin
					index_a <= ia;
					index_b <= ib;
					index_c <= ic;
				end else if (row_q == 9'd0) begin
					pos_y <= {1'b0, rad};
					norm_y <= 16'd16384;
				end else if (row_q == t_eff) begin
					pos_y <= -{1'b0, rad};
					norm_y <= -16'd16384;
					tex_v <= 17'd65536;
				end else begin
					pos_x <= px_q;
					pos_y <= py_q;
					pos_z <= pz_q;
					norm_x <= to_norm(dx_q);
					norm_y <= to_norm(dy_q);
					norm_z <= to_norm(dz_q);
					tex_u <= tu_q;
					tex_v <= tv_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
